>>> rtl/shbt_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// shbt_pkg
// Shared constants and controller/datapath interface types for the string
// hash bucket table.
// ----------------------------------------------------------------------------
package shbt_pkg;

    // Field widths
    localparam int KEY_W         = 8;
    localparam int HASH_W        = 32;
    localparam int STORE_VALUE_W = 32;
    localparam int OUT_VALUE_W   = 32;

    // hash * 31 is computed as (hash << 5) - hash
    localparam int HASH_MULT_SHIFT = 5;

    // Parameter defaults
    localparam int BUCKETS_DEF     = 4096;
    localparam int VALUE_WIDTH_DEF = 32;

    // Request codes
    localparam logic REQ_STORE    = 1'b0;
    localparam logic REQ_RETRIEVE = 1'b1;

    // Controller to datapath
    typedef struct packed {
        logic clr_step;   // write an empty entry at the sweep address, advance
        logic accept;     // input transaction taken this cycle
        logic red_step;   // one step of the bucket remainder
        logic ram_wr;     // write the store entry
        logic ram_rd;     // read the bucket for a retrieve
        logic out_load;   // load the result register
    } t_dp_cmd;

    // Datapath to controller
    typedef struct packed {
        logic clr_last;      // sweep address is the final bucket
        logic red_needed;    // bucket count is not a power of two
        logic red_last;      // remainder unit on its final step
        logic is_store;      // pending key access is a store
    } t_dp_status;

endpackage

>>> rtl/shbt_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// shbt_ram
// Generic simple dual-port RAM: one write port, one read port with
// registered read data.
// ----------------------------------------------------------------------------
module shbt_ram #(
    parameter int WIDTH = 33,
    parameter int DEPTH = 4096
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // Registered read port, holds between reads
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

>>> rtl/shbt_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// shbt_datapath
// Running polynomial hash, bucket index reduction, bucket table with valid
// marks and the result register.
// ----------------------------------------------------------------------------
module shbt_datapath #(
    parameter int BUCKETS     = shbt_pkg::BUCKETS_DEF,
    parameter int VALUE_WIDTH = shbt_pkg::VALUE_WIDTH_DEF
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  shbt_pkg::t_dp_cmd                    i_cmd,
    output shbt_pkg::t_dp_status                 o_status,
    input  logic                                 i_req_type,
    input  logic [shbt_pkg::KEY_W-1:0]           i_key_byte,
    input  logic                                 i_byte_present,
    input  logic                                 i_last_byte,
    input  logic [shbt_pkg::STORE_VALUE_W-1:0]   i_store_value,
    output logic                                 o_found,
    output logic [shbt_pkg::OUT_VALUE_W-1:0]     o_value
);

    import shbt_pkg::*;

    localparam int IW      = $clog2(BUCKETS);
    localparam bit IS_POW2 = ((BUCKETS & (BUCKETS - 1)) == 0);
    localparam int RW      = VALUE_WIDTH + 1;

    logic [HASH_W-1:0]        r_hash;
    logic [HASH_W-1:0]        n_hash;
    logic [IW-1:0]            w_idx;
    logic [IW-1:0]            r_clr_addr;
    logic                     r_req;
    logic [STORE_VALUE_W-1:0] r_sval;
    logic [VALUE_WIDTH-1:0]   w_sval;
    logic                     w_key_end;
    logic                     w_wr_en;
    logic [IW-1:0]            w_wr_addr;
    logic [RW-1:0]            w_wr_data;
    logic [RW-1:0]            w_rd_data;
    logic [OUT_VALUE_W-1:0]   w_rd_val;
    logic                     r_found;
    logic [OUT_VALUE_W-1:0]   r_value;

    assign w_key_end = i_cmd.accept && i_last_byte;

    // Fold the next byte: hash * 31 + byte, wrapping
    always_comb begin
        n_hash = r_hash;
        if (i_byte_present) begin
            n_hash = (r_hash << HASH_MULT_SHIFT) - r_hash
                     + {{(HASH_W - KEY_W){1'b0}}, i_key_byte};
        end
    end

    // Hold the hash across a key, restart after its last byte
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hash <= '0;
        end else if (i_cmd.accept) begin
            r_hash <= i_last_byte ? '0 : n_hash;
        end
    end

    // Capture the request of the key's last byte
    always_ff @(posedge i_clk) begin
        if (w_key_end) begin
            r_req  <= i_req_type;
            r_sval <= i_store_value;
        end
    end

    // Bucket index: low hash bits, or a two-step reciprocal-multiply remainder
    generate
        if (IS_POW2) begin : g_mask
            logic [IW-1:0] r_idx;

            always_ff @(posedge i_clk) begin
                if (w_key_end) begin
                    r_idx <= n_hash[IW-1:0];
                end
            end

            assign w_idx               = r_idx;
            assign o_status.red_needed = 1'b0;
            assign o_status.red_last   = 1'b1;
        end else begin : g_rem
            localparam int                MW    = HASH_W + 1;
            localparam logic [63:0]       R_NUM = 64'd1 << (HASH_W + IW);
            localparam logic [MW-1:0]     RECIP =
                MW'((R_NUM + 64'(BUCKETS) - 64'd1) / 64'(BUCKETS));
            localparam logic [HASH_W-1:0] BKT_C = HASH_W'(BUCKETS);

            logic [HASH_W-1:0]    r_div;
            logic [HASH_W-1:0]    r_quo;
            logic [IW-1:0]        r_rem;
            logic                 r_phase;
            logic [HASH_W+MW-1:0] w_prod;
            logic [HASH_W-1:0]    w_back;
            logic [HASH_W-1:0]    w_rem_full;

            // Quotient by the rounded-up reciprocal, exact for any 32-bit hash
            assign w_prod     = {{MW{1'b0}}, r_div} * {{HASH_W{1'b0}}, RECIP};
            // Remainder: hash minus quotient times bucket count
            assign w_back     = r_quo * BKT_C;
            assign w_rem_full = r_div - w_back;

            // Step one loads the quotient, step two the remainder
            always_ff @(posedge i_clk) begin
                if (!i_rst_n) begin
                    r_phase <= 1'b0;
                end else if (w_key_end) begin
                    r_phase <= 1'b0;
                end else if (i_cmd.red_step) begin
                    r_phase <= 1'b1;
                end
            end

            always_ff @(posedge i_clk) begin
                if (w_key_end) begin
                    r_div <= n_hash;
                end else if (i_cmd.red_step) begin
                    if (!r_phase) begin
                        r_quo <= HASH_W'(w_prod >> (HASH_W + IW));
                    end else begin
                        r_rem <= w_rem_full[IW-1:0];
                    end
                end
            end

            assign w_idx               = r_rem;
            assign o_status.red_needed = 1'b1;
            assign o_status.red_last   = r_phase;
        end
    endgenerate

    // Store value trimmed or extended to the table width
    generate
        if (VALUE_WIDTH <= STORE_VALUE_W) begin : g_sval_trim
            assign w_sval = r_sval[VALUE_WIDTH-1:0];
        end else begin : g_sval_ext
            assign w_sval = {{(VALUE_WIDTH - STORE_VALUE_W){1'b0}}, r_sval};
        end
    endgenerate

    // Sweep address for the post-reset clearing pass
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_addr <= '0;
        end else if (i_cmd.clr_step) begin
            r_clr_addr <= r_clr_addr + 1'b1;
        end
    end

    // Table write: empty entries during the sweep, valid entries on a store
    assign w_wr_en   = i_cmd.clr_step || i_cmd.ram_wr;
    assign w_wr_addr = i_cmd.clr_step ? r_clr_addr : w_idx;
    assign w_wr_data = i_cmd.clr_step ? '0 : {1'b1, w_sval};

    shbt_ram #(
        .WIDTH (RW),
        .DEPTH (BUCKETS)
    ) u_table (
        .i_clk     (i_clk),
        .i_wr_en   (w_wr_en),
        .i_wr_addr (w_wr_addr),
        .i_wr_data (w_wr_data),
        .i_rd_en   (i_cmd.ram_rd),
        .i_rd_addr (w_idx),
        .o_rd_data (w_rd_data)
    );

    // Stored value fitted to the output field
    generate
        if (VALUE_WIDTH >= OUT_VALUE_W) begin : g_out_trim
            assign w_rd_val = w_rd_data[OUT_VALUE_W-1:0];
        end else begin : g_out_ext
            assign w_rd_val = {{(OUT_VALUE_W - VALUE_WIDTH){1'b0}},
                               w_rd_data[VALUE_WIDTH-1:0]};
        end
    endgenerate

    // Result register, value forced to zero on a miss
    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_found <= w_rd_data[VALUE_WIDTH];
            r_value <= w_rd_data[VALUE_WIDTH] ? w_rd_val : '0;
        end
    end

    assign o_status.clr_last = (r_clr_addr == IW'(BUCKETS - 1));
    assign o_status.is_store = (r_req == REQ_STORE);
    assign o_found           = r_found;
    assign o_value           = r_value;

endmodule

>>> rtl/shbt_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// shbt_ctrl
// Sequencer for the bucket table: clearing pass, byte intake, index
// reduction, table access and result handoff.
// ----------------------------------------------------------------------------
module shbt_ctrl (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    input  logic                 i_last_byte,
    input  logic                 i_out_stall,
    input  shbt_pkg::t_dp_status i_status,
    output shbt_pkg::t_dp_cmd    o_cmd,
    output logic                 o_in_stall,
    output logic                 o_out_valid
);

    import shbt_pkg::*;

    typedef enum logic [4:0] {
        ST_CLEAR   = 5'b00001,
        ST_IDLE    = 5'b00010,
        ST_REDUCE  = 5'b00100,
        ST_ACCESS  = 5'b01000,
        ST_RESPOND = 5'b10000
    } t_state;

    t_state  r_state;
    t_state  n_state;
    logic    r_out_valid;
    logic    n_out_valid;
    logic    w_in_take;
    logic    w_out_free;

    assign o_in_stall = (r_state != ST_IDLE);
    assign w_in_take  = i_in_valid && !o_in_stall;
    assign w_out_free = !r_out_valid || !i_out_stall;

    // Next state and commands
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            ST_CLEAR: begin
                o_cmd.clr_step = 1'b1;
                if (i_status.clr_last) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                o_cmd.accept = w_in_take;
                if (w_in_take && i_last_byte) begin
                    n_state = i_status.red_needed ? ST_REDUCE : ST_ACCESS;
                end
            end
            ST_REDUCE: begin
                o_cmd.red_step = 1'b1;
                if (i_status.red_last) begin
                    n_state = ST_ACCESS;
                end
            end
            ST_ACCESS: begin
                if (i_status.is_store) begin
                    o_cmd.ram_wr = 1'b1;
                    n_state      = ST_IDLE;
                end else begin
                    o_cmd.ram_rd = 1'b1;
                    n_state      = ST_RESPOND;
                end
            end
            ST_RESPOND: begin
                if (w_out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_CLEAR;
            end
        endcase
    end

    // Result valid: set on load, drop when the transaction is taken
    always_comb begin
        n_out_valid = r_out_valid;
        if (o_cmd.out_load) begin
            n_out_valid = 1'b1;
        end else if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_CLEAR;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_out_valid = r_out_valid;

endmodule

>>> rtl/string_hash_bucket_table_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// string_hash_bucket_table_core
// Direct-mapped hash table keyed by byte strings with a 31-polynomial hash.
// ----------------------------------------------------------------------------
// Key bytes enter one per transaction and fold into a 32-bit hash
// (hash * 31 + byte, wrapping); the transaction marked last_byte selects
// bucket hash mod BUCKETS, where a store writes the value and sets the
// bucket valid, and a retrieve returns found and the value (zero on a miss).
// Keys are not compared, so keys landing in the same bucket alias. A byte
// that does not end a key is folded into the hash; a key-ending store then
// writes the table, and a key-ending retrieve does a registered table read,
// then loads the result register. When BUCKETS is not a power of two
// a reciprocal-multiply remainder unit adds a quotient step and a remainder
// step before the table access. After reset the block sweeps the table to
// clear all valid marks, one bucket per cycle over all BUCKETS buckets
// (4096 by default), and holds input stall high until it is done. A result
// waiting on output stall does not block bytes or stores; the next key-ending
// retrieve waits, with input stalled, until the waiting result is taken.
// ----------------------------------------------------------------------------
module string_hash_bucket_table_core #(
    parameter int BUCKETS     = shbt_pkg::BUCKETS_DEF,
    parameter int VALUE_WIDTH = shbt_pkg::VALUE_WIDTH_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_in_valid,
    output logic                               o_in_stall,
    input  logic                               i_req_type,
    input  logic [shbt_pkg::KEY_W-1:0]         i_key_byte,
    input  logic                               i_byte_present,
    input  logic                               i_last_byte,
    input  logic [shbt_pkg::STORE_VALUE_W-1:0] i_store_value,
    output logic                               o_out_valid,
    input  logic                               i_out_stall,
    output logic                               o_found,
    output logic [shbt_pkg::OUT_VALUE_W-1:0]   o_value
);

    import shbt_pkg::*;

    t_dp_cmd    w_cmd;
    t_dp_status w_status;

    // Sequencer
    shbt_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_last_byte (i_last_byte),
        .i_out_stall (i_out_stall),
        .i_status    (w_status),
        .o_cmd       (w_cmd),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid)
    );

    // Hash, index and table
    shbt_datapath #(
        .BUCKETS     (BUCKETS),
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_datapath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (w_cmd),
        .o_status       (w_status),
        .i_req_type     (i_req_type),
        .i_key_byte     (i_key_byte),
        .i_byte_present (i_byte_present),
        .i_last_byte    (i_last_byte),
        .i_store_value  (i_store_value),
        .o_found        (o_found),
        .o_value        (o_value)
    );

`ifndef SYNTHESIS
    // A result is never loaded over one that is still stalled
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.out_load |-> !(o_out_valid && i_out_stall))
        else $error("result register overwritten while stalled");

    // A loaded result is presented in the next cycle
    a_load_shows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.out_load |=> o_out_valid)
        else $error("loaded result not presented");

    // No byte is taken while the index is reduced or the table accessed
    a_busy_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_cmd.red_step || w_cmd.ram_wr || w_cmd.ram_rd) |-> o_in_stall)
        else $error("input taken during table access");

    // The clearing pass after reset holds off input
    a_reset_stall: assert property (@(posedge i_clk)
        !i_rst_n |=> o_in_stall)
        else $error("input not stalled after reset");
`endif

endmodule

>>> tb/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// String hash bucket table testbench
// Sends keys one byte per transaction, with the hash folded by a local copy of
// the table, and checks every retrieve result in order against that copy.
// Covers empty keys, absent bytes, colliding keys, long wrapping hashes and
// random store/retrieve traffic with idle gaps on both sides.
// ----------------------------------------------------------------------------

// Track the hash and table contents and hold the retrieve results still due.
class bucket_table_scoreboard;

    typedef struct {
        logic                             found;
        logic [shbt_pkg::OUT_VALUE_W-1:0] value;
    } t_lookup;

    localparam int unsigned BUCKETS = shbt_pkg::BUCKETS_DEF;

    logic [shbt_pkg::HASH_W-1:0]      hash_acc;
    bit                               bucket_used [BUCKETS];
    logic [shbt_pkg::OUT_VALUE_W-1:0] bucket_data [BUCKETS];
    t_lookup                          due_lookups [$];
    int                               errors;
    int                               results_seen;

    function new();
        hash_acc = '0;
        foreach (bucket_used[i]) bucket_used[i] = 1'b0;
        errors = 0;
        results_seen = 0;
    endfunction

    function int pending();
        return due_lookups.size();
    endfunction

    // Fold one accepted transaction into the hash; access the table on a key end.
    function void note_input(logic req, logic [shbt_pkg::KEY_W-1:0] kb, logic present,
                             logic last, logic [shbt_pkg::STORE_VALUE_W-1:0] sval);
        int unsigned idx;
        t_lookup     res;
        if (present) begin
            hash_acc = hash_acc * 32'd31 + {24'd0, kb};
        end
        if (last) begin
            idx = hash_acc % BUCKETS;
            if (req == shbt_pkg::REQ_STORE) begin
                bucket_data[idx] = sval;
                bucket_used[idx] = 1'b1;
            end else begin
                res.found = bucket_used[idx];
                res.value = bucket_used[idx] ? bucket_data[idx] : '0;
                due_lookups.push_back(res);
            end
            hash_acc = '0;
        end
    endfunction

    // Compare one accepted result with the oldest lookup still due.
    function void check_result(logic found, logic [shbt_pkg::OUT_VALUE_W-1:0] value);
        t_lookup exp_res;
        results_seen++;
        if (due_lookups.size() == 0) begin
            $display("%0t: unexpected result found=%0d value=%h", $time, found, value);
            errors++;
        end else begin
            exp_res = due_lookups.pop_front();
            if (found !== exp_res.found) begin
                $display("%0t: found mismatch, expected %0d actual %0d",
                         $time, exp_res.found, found);
                errors++;
            end
            if (value !== exp_res.value) begin
                $display("%0t: value mismatch, expected %h actual %h",
                         $time, exp_res.value, value);
                errors++;
            end
        end
    endfunction

endclass

module testbench;

    import shbt_pkg::*;

    localparam int ITEM_TARGET  = 1950;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int POOL_KEYS    = 16;
    localparam int POOL_MAX_LEN = 10;

    typedef enum int {STALL_NONE, STALL_LIGHT, STALL_HEAVY, STALL_PATTERN} t_stall_mode;

    logic                     i_clk          = 1'b0;
    logic                     i_rst_n        = 1'b0;
    logic                     i_in_valid     = 1'b0;
    logic                     i_req_type     = REQ_STORE;
    logic [KEY_W-1:0]         i_key_byte     = '0;
    logic                     i_byte_present = 1'b0;
    logic                     i_last_byte    = 1'b0;
    logic [STORE_VALUE_W-1:0] i_store_value  = '0;
    logic                     i_out_stall    = 1'b0;
    logic                     o_in_stall;
    logic                     o_out_valid;
    logic                     o_found;
    logic [OUT_VALUE_W-1:0]   o_value;

    bucket_table_scoreboard sb = new();

    int          cycles      = 0;
    int          items_sent  = 0;
    int          burst_left  = 0;
    t_stall_mode stall_mode  = STALL_NONE;
    int          stall_left  = 0;
    int          stall_phase = 0;

    logic [KEY_W-1:0] pool_key [0:POOL_KEYS-1][0:POOL_MAX_LEN-1];
    int               pool_len [0:POOL_KEYS-1];

    string_hash_bucket_table_core i_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_req_type     (i_req_type),
        .i_key_byte     (i_key_byte),
        .i_byte_present (i_byte_present),
        .i_last_byte    (i_last_byte),
        .i_store_value  (i_store_value),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_found        (o_found),
        .o_value        (o_value)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // Abort a hung run.
    always @(posedge i_clk) begin
        cycles++;
        if (cycles >= CYCLE_LIMIT) begin
            $display("FAILURE");
            $finish;
        end
    end

    // Watch both channels at the rising edge.
    always @(posedge i_clk) begin
        if (i_rst_n && i_in_valid && !o_in_stall) begin
            sb.note_input(i_req_type, i_key_byte, i_byte_present, i_last_byte, i_store_value);
        end
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            sb.check_result(o_found, o_value);
        end
    end

    // Stall the result channel in changing modes: none, light, heavy, fixed pattern.
    always @(negedge i_clk) begin
        if (stall_left == 0) begin
            stall_mode = t_stall_mode'($urandom_range(0, 3));
            stall_left = $urandom_range(16, 200);
        end
        stall_left--;
        stall_phase++;
        case (stall_mode)
            STALL_NONE:  i_out_stall = 1'b0;
            STALL_LIGHT: i_out_stall = ($urandom_range(0, 3) == 0);
            STALL_HEAVY: i_out_stall = ($urandom_range(0, 3) != 0);
            default:     i_out_stall = ((stall_phase % 7) < 3);
        endcase
    end

    // Send one transaction; open a new burst after a random gap when the last one ran out.
    task automatic drive_item(input logic req, input logic [KEY_W-1:0] kb, input logic present,
                              input logic last, input logic [STORE_VALUE_W-1:0] sval);
        int gap;
        if (burst_left == 0) begin
            gap = $urandom_range(1, 6);
            repeat (gap) begin
                @(negedge i_clk);
                i_in_valid     = 1'b0;
                i_req_type     = 1'($urandom_range(0, 1));
                i_key_byte     = KEY_W'($urandom);
                i_byte_present = 1'($urandom_range(0, 1));
                i_last_byte    = 1'($urandom_range(0, 1));
                i_store_value  = $urandom;
            end
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(50, 120)
                                                     : $urandom_range(1, 20);
        end
        burst_left--;
        @(negedge i_clk);
        i_in_valid     = 1'b1;
        i_req_type     = req;
        i_key_byte     = kb;
        i_byte_present = present;
        i_last_byte    = last;
        i_store_value  = sval;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        if (present || last) items_sent++;
    endtask

    // Hold off the sender until every lookup result has come back.
    task automatic drain_lookups();
        while (sb.pending() != 0) @(posedge i_clk);
    endtask

    function automatic logic [KEY_W-1:0] pick_key_byte();
        case ($urandom_range(0, 5))
            0:       return 8'h00;
            1:       return 8'hFF;
            2:       return 8'h41 + KEY_W'($urandom_range(0, 25));
            default: return KEY_W'($urandom);
        endcase
    endfunction

    function automatic logic [STORE_VALUE_W-1:0] pick_store_value();
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return '1;
            default: return $urandom;
        endcase
    endfunction

    // Replace one pool key with a fresh one, mostly short.
    task automatic refresh_key(input int slot);
        pool_len[slot] = ($urandom_range(0, 5) == 0) ? $urandom_range(5, POOL_MAX_LEN)
                                                     : $urandom_range(0, 4);
        for (int k = 0; k < POOL_MAX_LEN; k++) pool_key[slot][k] = pick_key_byte();
    endtask

    // Send a pool key, with stray empty slots mid-key and ignored fields randomized.
    task automatic send_key(input logic req, input int slot, input logic [STORE_VALUE_W-1:0] sval);
        int  len;
        logic tail_empty;
        len = pool_len[slot];
        tail_empty = (len == 0) || ($urandom_range(0, 7) == 0);
        for (int k = 0; k < len; k++) begin
            if ($urandom_range(0, 9) == 0) begin
                drive_item(1'($urandom_range(0, 1)), KEY_W'($urandom), 1'b0, 1'b0, $urandom);
            end
            if (k == len - 1 && !tail_empty) begin
                drive_item(req, pool_key[slot][k], 1'b1, 1'b1, sval);
            end else begin
                drive_item(1'($urandom_range(0, 1)), pool_key[slot][k], 1'b1, 1'b0, $urandom);
            end
        end
        if (tail_empty) begin
            drive_item(req, KEY_W'($urandom), 1'b0, 1'b1, sval);
        end
    endtask

    initial begin
        int  slot;
        logic req;
        bit  paused;

        repeat (11) @(negedge i_clk);
        i_rst_n = 1'b1;

        // Empty bucket, empty key, and keys that land on bucket zero.
        drive_item(REQ_RETRIEVE, 8'h5A, 1'b0, 1'b1, 32'h1357_9BDF);
        drive_item(REQ_STORE,    8'hC3, 1'b0, 1'b1, 32'hFFFF_FFFF);
        drive_item(REQ_RETRIEVE, 8'h00, 1'b1, 1'b1, 32'h0);
        // Full hashes 4096 and 0 share bucket zero.
        drive_item(REQ_RETRIEVE, 8'd132, 1'b1, 1'b0, 32'hFFFF_FFFF);
        drive_item(REQ_STORE,    8'd4,   1'b1, 1'b1, 32'h0000_0000);
        drive_item(REQ_STORE,    8'h00,  1'b1, 1'b0, 32'hDEAD_BEEF);
        drive_item(REQ_RETRIEVE, 8'hFF,  1'b0, 1'b1, 32'h0);
        // Equal full hashes: "Aa" and "BB".
        drive_item(REQ_RETRIEVE, 8'h41, 1'b1, 1'b0, 32'h0);
        drive_item(REQ_STORE,    8'h61, 1'b1, 1'b1, 32'hA5A5_A5A5);
        drive_item(REQ_STORE,    8'h42, 1'b1, 1'b0, 32'hFFFF_FFFF);
        drive_item(REQ_RETRIEVE, 8'h42, 1'b1, 1'b1, 32'h0);
        // Long all-ones key wraps the hash.
        for (int k = 0; k < 6; k++) begin
            drive_item(k == 5 ? REQ_STORE : REQ_RETRIEVE, 8'hFF, 1'b1, k == 5, 32'h1234_5678);
        end
        for (int k = 0; k < 6; k++) begin
            if (k == 3) drive_item(REQ_STORE, 8'h00, 1'b0, 1'b0, 32'hFFFF_FFFF);
            drive_item(k == 5 ? REQ_RETRIEVE : REQ_STORE, 8'hFF, 1'b1, k == 5, 32'h0);
        end
        drain_lookups();

        for (int s = 0; s < POOL_KEYS; s++) refresh_key(s);

        // Random store/retrieve traffic over an evolving key pool.
        paused = 1'b0;
        while (items_sent < ITEM_TARGET) begin
            slot = $urandom_range(0, POOL_KEYS - 1);
            if ($urandom_range(0, 4) == 0) refresh_key(slot);
            req = ($urandom_range(0, 19) < 11) ? REQ_RETRIEVE : REQ_STORE;
            send_key(req, slot, pick_store_value());
            if (!paused && items_sent >= ITEM_TARGET / 2) begin
                drain_lookups();
                paused = 1'b1;
            end
        end

        @(negedge i_clk);
        i_in_valid = 1'b0;
        drain_lookups();
        repeat (10) @(posedge i_clk);
        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
